// File: rtl/core/permutation_rank_unrank_top_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef PERMUTATION_RANK_UNRANK_TOP_MACROS_SVH
`define PERMUTATION_RANK_UNRANK_TOP_MACROS_SVH

// same-cycle implication
`define PRUR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define PRUR_ASSERT_DLY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// File: rtl/core/prur_pkg.sv
package prur_pkg;

  localparam int STAGE    = 7;
  localparam int NPOS     = 7;
  localparam int USED_POS = (STAGE < NPOS) ? STAGE : NPOS;

  localparam int SYM_W  = 3;
  localparam int RANK_W = 13;
  localparam int POS_W  = $clog2(NPOS);
  localparam int CNT_W  = $clog2(NPOS + 1);

  // front register, one register per position, output register
  localparam int LATENCY = USED_POS + 2;

  localparam logic OP_RANK   = 1'b0;
  localparam logic OP_UNRANK = 1'b1;

  localparam logic [RANK_W-1:0] FACT [NPOS+1] = '{
    13'd1, 13'd1, 13'd2, 13'd6, 13'd24, 13'd120, 13'd720, 13'd5040
  };

  localparam logic [RANK_W-1:0] RANK_LIMIT = FACT[USED_POS];

  typedef struct packed {
    logic             op;
    logic [SYM_W-1:0] sym_0;
    logic [SYM_W-1:0] sym_1;
    logic [SYM_W-1:0] sym_2;
    logic [SYM_W-1:0] sym_3;
    logic [SYM_W-1:0] sym_4;
    logic [SYM_W-1:0] sym_5;
    logic [SYM_W-1:0] sym_6;
    logic [RANK_W-1:0] rank_in;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank_out;
    logic [SYM_W-1:0]  out_0;
    logic [SYM_W-1:0]  out_1;
    logic [SYM_W-1:0]  out_2;
    logic [SYM_W-1:0]  out_3;
    logic [SYM_W-1:0]  out_4;
    logic [SYM_W-1:0]  out_5;
    logic [SYM_W-1:0]  out_6;
    logic              range_error;
  } out_item_t;

  typedef logic [NPOS-1:0][SYM_W-1:0] sym_vec_t;

  typedef struct packed {
    logic              op;
    logic              err;
    logic [RANK_W-1:0] rem;
    logic [RANK_W-1:0] total;
    sym_vec_t          syms;
    sym_vec_t          pool;
    sym_vec_t          outs;
  } pipe_t;

endpackage

// File: rtl/core/prur_front.sv
module prur_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  prur_pkg::in_item_t in_item,
  output logic              out_valid,
  output prur_pkg::pipe_t   out_st
);
  import prur_pkg::*;

  logic  valid_r;
  pipe_t st_r;
  pipe_t st_nxt;

  always_comb begin
    st_nxt.op    = in_item.op;
    st_nxt.err   = (in_item.op == OP_UNRANK) && (in_item.rank_in >= RANK_LIMIT);
    st_nxt.rem   = in_item.rank_in;
    st_nxt.total = '0;
    st_nxt.syms  = {in_item.sym_6, in_item.sym_5, in_item.sym_4, in_item.sym_3,
                    in_item.sym_2, in_item.sym_1, in_item.sym_0};
    for (int k = 0; k < NPOS; k++) begin
      st_nxt.pool[k] = SYM_W'(k);
    end
    st_nxt.outs = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;

endmodule

// File: rtl/core/prur_stage.sv
module prur_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [prur_pkg::POS_W-1:0] pos,
  input  logic                       in_valid,
  input  prur_pkg::pipe_t            in_st,
  output logic                       out_valid,
  output prur_pkg::pipe_t            out_st
);
  import prur_pkg::*;

  logic             valid_r;
  pipe_t            st_r;
  pipe_t            st_nxt;
  logic [CNT_W-1:0] left;
  logic [POS_W-1:0] idx;
  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] dig;
  logic [SYM_W-1:0] sel;

  // positions still to go, including this one
  assign left = CNT_W'(USED_POS) - CNT_W'(pos);
  assign idx  = POS_W'(left - CNT_W'(1));

  always_comb begin
    cnt = '0;
    dig = '0;
    for (int j = 1; j < NPOS; j++) begin
      // rank: later symbols smaller than the head
      if ((CNT_W'(j) < left) && (in_st.syms[j] < in_st.syms[0])) begin
        cnt = cnt + CNT_W'(1);
      end
      // unrank: quotient digit by threshold compares
      if ((CNT_W'(j) < left) && (in_st.rem >= RANK_W'(j * FACT[idx]))) begin
        dig = dig + POS_W'(1);
      end
    end
  end

  assign sel = in_st.pool[dig];

  always_comb begin
    st_nxt       = in_st;
    st_nxt.total = in_st.total + RANK_W'(cnt * FACT[idx]);
    st_nxt.rem   = in_st.rem - RANK_W'(dig * FACT[idx]);
    for (int k = 0; k < NPOS - 1; k++) begin
      st_nxt.syms[k] = in_st.syms[k+1];
      st_nxt.outs[k] = in_st.outs[k+1];
      // drop the chosen symbol from the pool
      st_nxt.pool[k] = (POS_W'(k) < dig) ? in_st.pool[k] : in_st.pool[k+1];
    end
    st_nxt.syms[NPOS-1] = '0;
    st_nxt.outs[NPOS-1] = sel;
    st_nxt.pool[NPOS-1] = in_st.pool[NPOS-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;

endmodule

// File: rtl/core/prur_back.sv
module prur_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  prur_pkg::pipe_t     in_st,
  output logic                out_valid,
  output prur_pkg::out_item_t out_item
);
  import prur_pkg::*;

  logic      valid_r;
  out_item_t item_r;
  out_item_t item_nxt;
  sym_vec_t  al;
  logic      good_unrank;

  // symbols were shifted in at the top end, one per position
  for (genvar k = 0; k < NPOS; k++) begin : g_align
    if (k < USED_POS) begin : g_used
      assign al[k] = in_st.outs[NPOS-USED_POS+k];
    end else begin : g_unused
      assign al[k] = '0;
    end
  end

  assign good_unrank = (in_st.op == OP_UNRANK) && !in_st.err;

  always_comb begin
    item_nxt.rank_out    = (in_st.op == OP_RANK) ? in_st.total : '0;
    item_nxt.out_0       = good_unrank ? al[0] : '0;
    item_nxt.out_1       = good_unrank ? al[1] : '0;
    item_nxt.out_2       = good_unrank ? al[2] : '0;
    item_nxt.out_3       = good_unrank ? al[3] : '0;
    item_nxt.out_4       = good_unrank ? al[4] : '0;
    item_nxt.out_5       = good_unrank ? al[5] : '0;
    item_nxt.out_6       = good_unrank ? al[6] : '0;
    item_nxt.range_error = (in_st.op == OP_UNRANK) && in_st.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// File: rtl/core/permutation_rank_unrank_top.sv
// permutation rank / unrank, seven symbols, lexicographic (factoradic) order
//
// input: drive in_item and raise start; the item is taken at a rising edge
// with start high and busy low. busy is high only while rst_n is low, so after
// reset an item can be given in every cycle. in_item.op selects rank
// (sym_0..sym_6 -> rank_out) or unrank (rank_in -> out_0..out_6). an unrank
// of 5040 or more sets range_error.
//
// output: out_valid is high for one cycle with out_item; the item is taken
// at the edge that ends that cycle. the receiver cannot stall the block.
//
// pipeline: from the accepting edge the item passes the input register, one
// register per symbol position and the output register to the result.
// throughput: one item per cycle, set by the per-position stage,
// where one compare group handles one digit of the code.
//
// reset: synchronous, active low rst_n; all valid bits are cleared and any
// item in flight is dropped. no configuration.
module permutation_rank_unrank_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  prur_pkg::in_item_t  in_item,
  output logic                out_valid,
  output prur_pkg::out_item_t out_item
);
  import prur_pkg::*;

  `include "permutation_rank_unrank_top_macros.svh"

  pipe_t st   [USED_POS+1];
  logic  vld  [USED_POS+1];
  logic  in_valid;

  // no item is taken while the pipeline is held in reset
  assign busy     = !rst_n;
  assign in_valid = start && !busy;

  prur_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .out_valid(vld[0]),
    .out_st   (st[0])
  );

  for (genvar g = 0; g < USED_POS; g++) begin : g_pos
    prur_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .pos      (POS_W'(g)),
      .in_valid (vld[g]),
      .in_st    (st[g]),
      .out_valid(vld[g+1]),
      .out_st   (st[g+1])
    );
  end

  prur_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vld[USED_POS]),
    .in_st    (st[USED_POS]),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  `PRUR_ASSERT_DLY(a_latency, in_valid, LATENCY, out_valid, "result missing after accepted item")
  `PRUR_ASSERT_IMPL(a_no_spurious, out_valid, $past(in_valid, LATENCY),
                    "result without an accepted item")
  `PRUR_ASSERT_IMPL(a_err_zero, out_valid && out_item.range_error,
                    (out_item.rank_out == '0) && (out_item.out_0 == '0) &&
                    (out_item.out_3 == '0) && (out_item.out_6 == '0),
                    "range error with nonzero result fields")
  `PRUR_ASSERT_IMPL(a_one_mode, out_valid,
                    (out_item.rank_out == '0) ||
                    ((out_item.out_0 == '0) && (out_item.out_1 == '0) &&
                     (out_item.out_6 == '0) && !out_item.range_error),
                    "rank and unrank fields both set")

endmodule
